[design/pds_pkg.sv]
// ----------------------------------------------------------------------------
// pds_pkg: shared types and constants of the pentadiagonal system solver
// Word formats, fixed-point helpers and controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned DIV_W     = 32 + FRAC_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned FACT_W    = 96;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_ROWS = 2'd2;

  typedef struct packed {
    logic signed [31:0] sub2_coef;
    logic signed [31:0] sub1_coef;
    logic signed [31:0] main_diag;
    logic signed [31:0] sup1_coef;
    logic signed [31:0] sup2_coef;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } pds_in_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic [1:0]         status;
    logic               last_out;
  } pds_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FMUL, ST_FACC, ST_DWAIT, ST_WRITE, ST_ERR,
    ST_BRD, ST_BM1, ST_BA1, ST_BA2, ST_ORD, ST_OLD, ST_OUT
  } pds_state_e;

  // Saturate a wide sum to 32 bits.
  function automatic logic signed [31:0] sat32_f(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Scale a raw product back to Q format, round half up.
  function automatic logic signed [63:0] mulq_f(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (64'sd1 <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

endpackage

`default_nettype wire

[design/pds_ram.sv]
// ----------------------------------------------------------------------------
// pds_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[design/pds_div.sv]
// ----------------------------------------------------------------------------
// pds_div: iterative fixed-point divider
// Restoring division, one quotient bit per cycle, saturating Q result.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_div
  import pds_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);

  localparam logic [DIV_W-1:0] POS_MAX = DIV_W'(64'h7FFF_FFFF);
  localparam logic [DIV_W-1:0] NEG_MAG = DIV_W'(64'h8000_0000);

  logic                 busy_q, done_q, sign_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd_q;
  logic [31:0]          dsr_q, rem_q;
  logic [32:0]          rem_sh, rem_sub;
  logic                 ge;
  logic [31:0]          abs_n, abs_d;
  logic [DIV_W-1:0]     neg_q;

  always_comb begin
    abs_n   = num_i[31] ? (~num_i + 32'd1) : num_i;
    abs_d   = den_i[31] ? (~den_i + 32'd1) : den_i;
    rem_sh  = {rem_q, dvd_q[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dsr_q};
    rem_sub = rem_sh - {1'b0, dsr_q};
    neg_q   = ~dvd_q + DIV_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sign_q <= num_i[31] ^ den_i[31];
      dvd_q  <= {abs_n, {FRAC_BITS{1'b0}}};
      dsr_q  <= abs_d;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd_q <= {dvd_q[DIV_W-2:0], ge};
    end
  end

  always_comb begin
    if (!sign_q) begin
      quot_o = (dvd_q > POS_MAX) ? 32'sh7FFF_FFFF : dvd_q[31:0];
    end else begin
      quot_o = (dvd_q > NEG_MAG) ? 32'sh8000_0000 : neg_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[design/pentadiagonal_system_solver_top.sv]
// ----------------------------------------------------------------------------
// pentadiagonal_system_solver_top: streaming pentadiagonal solver, Q16.16
// Forward elimination per row, back substitution after the last row.
// ----------------------------------------------------------------------------
// Feed one matrix row per input word; the forward sweep runs while the block
// holds in_stall_o high, and the p, l and z factors of the row go to an
// on-chip factor RAM. A row takes six multiply steps on a single 32x32
// multiplier, three divisions by the pivot on one shared restoring divider
// of 48 iterations per quotient, and one write-back; the last row skips the
// fourth multiply step and the p and l divisions, and a row whose pivot is
// zero stops after its third multiply step. The word flagged last_row starts
// back substitution (states BRD, BM1, BA1 and BA2 per row, results parked in
// a solution RAM), then the solution comes out in ascending row_index order,
// one word at a time through ORD, OLD and OUT while out_stall_i is low, the
// final word carrying last_out. A zero pivot or more than 64 rows yields a
// single error word instead. No input word is taken while a solve is being
// delivered. The RAMs need no clearing after reset.
`default_nettype none

module pentadiagonal_system_solver_top
  import pds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pds_in_t  in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pds_out_t      out_word_o
);

  pds_state_e state_q, state_d;

  // latched row
  logic signed [31:0] e_q, c_q, d_q, a_q, b_q, f_q;
  logic               last_q;
  // forward sweep working values
  logic signed [31:0] y_q, q_q, p_q, l_q, z_q;
  logic signed [31:0] l1_q, l2_q, p1_q, p2_q, z1_q, z2_q;
  logic signed [63:0] acc_q, mul_q;
  logic [2:0]         step_q;
  logic [CNT_W-1:0]   row_cnt_q;
  logic [1:0]         err_q;
  // back substitution and delivery
  logic [IDX_W-1:0]   bi_q, k_q;
  logic signed [31:0] x1_q, x2_q;
  pds_out_t           out_q;
  logic               out_valid_q;

  logic signed [31:0] ma, mb, div_num, div_den, div_quot, diff;
  logic signed [63:0] mq;
  logic               div_start, div_done, in_acc, out_acc;
  logic [FACT_W-1:0]  fact_rd;
  logic [31:0]        x_rd;
  logic signed [31:0] p_rd, l_rd, z_rd;

  assign in_acc  = in_valid_i && (state_q == ST_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign p_rd = fact_rd[95:64];
  assign l_rd = fact_rd[63:32];
  assign z_rd = fact_rd[31:0];

  // Multiplier operand select
  always_comb begin
    ma = l2_q;
    mb = e_q;
    if (state_q == ST_BM1) begin
      ma = l_rd;
      mb = x1_q;
    end else if (state_q == ST_BA1) begin
      ma = p_rd;
      mb = x2_q;
    end else begin
      case (step_q)
        3'd0:    begin ma = l2_q; mb = e_q; end
        3'd1:    begin ma = p2_q; mb = e_q; end
        3'd2:    begin ma = l1_q; mb = y_q; end
        3'd3:    begin ma = p1_q; mb = y_q; end
        3'd4:    begin ma = z2_q; mb = e_q; end
        default: begin ma = z1_q; mb = y_q; end
      endcase
    end
  end

  assign mq   = mulq_f(mul_q);
  assign diff = sat32_f(acc_q - mq);

  always_comb begin
    div_den = (step_q == 3'd2) ? diff : q_q;
    case (step_q)
      3'd2:    div_num = b_q;
      3'd3:    div_num = sat32_f(64'(a_q) - mq);
      default: div_num = diff;
    endcase
  end

  // Controller: next state and strobes
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (row_cnt_q >= CNT_W'(MAX_ROWS) || err_q != STATUS_OK) begin
            state_d = in_word_i.last_row ? ST_ERR : ST_IDLE;
          end else begin
            state_d = ST_FMUL;
          end
        end
      end
      ST_FMUL: state_d = ST_FACC;
      ST_FACC: begin
        case (step_q)
          3'd2: begin
            if (diff == 32'sd0) begin
              state_d = last_q ? ST_ERR : ST_IDLE;
            end else if (last_q) begin
              state_d = ST_FMUL;
            end else begin
              div_start = 1'b1;
              state_d   = ST_DWAIT;
            end
          end
          3'd3, 3'd5: begin
            div_start = 1'b1;
            state_d   = ST_DWAIT;
          end
          default: state_d = ST_FMUL;
        endcase
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_d = (step_q == 3'd5) ? ST_WRITE : ST_FMUL;
        end
      end
      ST_WRITE: state_d = last_q ? ST_BRD : ST_IDLE;
      ST_ERR:   state_d = ST_OUT;
      ST_BRD:   state_d = ST_BM1;
      ST_BM1:   state_d = ST_BA1;
      ST_BA1:   state_d = ST_BA2;
      ST_BA2:   state_d = (bi_q == '0) ? ST_ORD : ST_BRD;
      ST_ORD:   state_d = ST_OLD;
      ST_OLD:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_acc) begin
          state_d = out_q.last_out ? ST_IDLE : ST_ORD;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control state: row count, error flag, previous-row factors, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= '0;
      err_q       <= STATUS_OK;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      l1_q <= '0; l2_q <= '0; p1_q <= '0; p2_q <= '0; z1_q <= '0; z2_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            step_q <= '0;
            if (row_cnt_q >= CNT_W'(MAX_ROWS)) begin
              if (err_q == STATUS_OK) begin
                err_q <= STATUS_ROWS;
              end
            end else if (err_q != STATUS_OK) begin
              row_cnt_q <= row_cnt_q + CNT_W'(1);
            end
          end
        end
        ST_FACC: begin
          case (step_q)
            3'd0: step_q <= 3'd1;
            3'd1: step_q <= 3'd2;
            3'd2: begin
              if (diff == 32'sd0) begin
                err_q     <= STATUS_ZERO;
                row_cnt_q <= row_cnt_q + CNT_W'(1);
              end else if (last_q) begin
                step_q <= 3'd4;
              end
            end
            3'd4: step_q <= 3'd5;
            default: ;
          endcase
        end
        ST_DWAIT: begin
          if (div_done && step_q != 3'd5) begin
            step_q <= step_q + 3'd1;
          end
        end
        ST_WRITE: begin
          row_cnt_q <= row_cnt_q + CNT_W'(1);
          l2_q <= l1_q; l1_q <= l_q;
          p2_q <= p1_q; p1_q <= p_q;
          z2_q <= z1_q; z1_q <= z_q;
        end
        ST_ERR, ST_OLD: out_valid_q <= 1'b1;
        ST_OUT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (out_q.last_out) begin
              // system done: start afresh
              row_cnt_q <= '0;
              err_q     <= STATUS_OK;
              l1_q <= '0; l2_q <= '0; p1_q <= '0;
              p2_q <= '0; z1_q <= '0; z2_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          e_q <= in_word_i.sub2_coef;
          c_q <= in_word_i.sub1_coef;
          d_q <= in_word_i.main_diag;
          a_q <= in_word_i.sup1_coef;
          b_q <= in_word_i.sup2_coef;
          f_q <= in_word_i.rhs_value;
          last_q <= in_word_i.last_row;
        end
      end
      ST_FMUL, ST_BM1: mul_q <= ma * mb;
      ST_FACC: begin
        case (step_q)
          3'd0: y_q   <= sat32_f(64'(c_q) - mq);
          3'd1: acc_q <= 64'(d_q) - mq;
          3'd2: begin
            q_q <= diff;
            p_q <= '0;
            l_q <= '0;
          end
          3'd4: acc_q <= 64'(f_q) - mq;
          default: ;
        endcase
      end
      ST_DWAIT: begin
        if (div_done) begin
          case (step_q)
            3'd2:    p_q <= div_quot;
            3'd3:    l_q <= div_quot;
            default: z_q <= div_quot;
          endcase
        end
      end
      ST_WRITE: begin
        bi_q <= row_cnt_q[IDX_W-1:0];
        x1_q <= '0;
        x2_q <= '0;
      end
      ST_BA1: begin
        acc_q <= 64'(z_rd) - mq;
        mul_q <= ma * mb;
      end
      ST_BA2: begin
        x2_q <= x1_q;
        x1_q <= diff;
        if (bi_q == '0) begin
          k_q <= '0;
        end else begin
          bi_q <= bi_q - IDX_W'(1);
        end
      end
      ST_ERR: begin
        out_q.solution  <= '0;
        out_q.row_index <= '0;
        out_q.status    <= err_q;
        out_q.last_out  <= 1'b1;
      end
      ST_OLD: begin
        out_q.solution  <= x_rd;
        out_q.row_index <= k_q;
        out_q.status    <= STATUS_OK;
        out_q.last_out  <= ({1'b0, k_q} + CNT_W'(1)) == row_cnt_q;
      end
      ST_OUT: begin
        if (out_acc && !out_q.last_out) begin
          k_q <= k_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  pds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // factors p, l, z of each row
  pds_ram #(.WIDTH(FACT_W), .DEPTH(MAX_ROWS)) u_fact_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (row_cnt_q[IDX_W-1:0]),
    .wdata_i ({p_q, l_q, z_q}),
    .raddr_i (bi_q),
    .rdata_o (fact_rd)
  );

  // solution components, written high to low, read low to high
  pds_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_sol_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_BA2),
    .waddr_i (bi_q),
    .wdata_i (diff),
    .raddr_i (k_q),
    .rdata_o (x_rd)
  );

  // No result word while a row may be taken.
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("output word valid while accepting rows");

  // Output valid drops after every accepted word, so words never come back to back.
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("output valid not dropped after handover");

  // An error word is always the only word of its solve.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != STATUS_OK |-> out_word_o.last_out)
    else $error("error word without last_out");

  // Row count never passes the store depth.
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= CNT_W'(MAX_ROWS))
    else $error("row count beyond store depth");

endmodule

`default_nettype wire
